/* hw/rtl/pyr_pkg.sv */
package pyr_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ANG_TABLE_LEN = 24;
  // Micro-rotations actually built; the angle table ends at 24 entries.
  localparam int unsigned CSTEPS = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN
                                                                  : CORDIC_STEPS;
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned PRE_SHIFT = 20;
  localparam int unsigned OPW = 18;
  localparam int unsigned CW = 40;
  localparam int unsigned ZW = 32;
  localparam int unsigned SQW = 32;
  localparam int unsigned ROOTW = 17;
  localparam logic [ZW-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam int unsigned CORDIC_LAT = CSTEPS + 2;
  localparam int unsigned PIPE_DEPTH = 1 + SQRT_STEPS + CORDIC_LAT;

  typedef struct packed {
    logic signed [15:0]    yaw_y;
    logic signed [OPW-1:0] pitch_y;
    logic signed [OPW-1:0] pitch_x;
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic                  degen;
  } carry_t;

  function automatic logic [ZW-1:0] ang_entry(input int unsigned idx);
    logic [ZW-1:0] r;
    unique case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A2F;
      19: r = 32'h00000517;
      20: r = 32'h0000028B;
      21: r = 32'h00000145;
      22: r = 32'h000000A2;
      23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/pyr_if.sv */
interface pyr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] elem_00;
  logic signed [15:0] elem_01;
  logic signed [15:0] elem_02;
  logic signed [15:0] elem_10;
  logic signed [15:0] elem_11;
  logic signed [15:0] elem_20;
  logic signed [15:0] elem_21;
  logic signed [15:0] elem_22;
  modport source (output valid, elem_00, elem_01, elem_02, elem_10, elem_11,
                  elem_20, elem_21, elem_22, input ready);
  modport sink (input valid, elem_00, elem_01, elem_02, elem_10, elem_11,
                elem_20, elem_21, elem_22, output ready);
endinterface

interface pyr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] roll_angle;
  modport source (output valid, pitch_angle, yaw_angle, roll_angle, input ready);
  modport sink (input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface

/* hw/rtl/pitch_yaw_roll_from_matrix.sv */
// Channel  Dir  Payload
// in_i     in   elem_00 .. elem_22, eight signed Q1.14 matrix elements
// out_o    out  pitch_angle, yaw_angle, roll_angle, signed binary angles
//
// One word enters per cycle while the pipeline is not halted; each result passes
// through 1 square stage, 16 square-root digit stages and 18 CORDIC stages.
// Reset clears only the valid bits of the pipeline.
// The whole pipeline advances together; it halts only while a result sits
// at the output and is not taken, and then in_i.ready is low.
module pitch_yaw_roll_from_matrix (
  input  logic       clk_i,
  input  logic       rst_ni,
  pyr_in_if.sink     in_i,
  pyr_out_if.source  out_o
);

  localparam int unsigned D = pyr_pkg::PIPE_DEPTH;
  localparam int unsigned OPW = pyr_pkg::OPW;

  logic [D-1:0] valid_q;
  logic         en;

  assign en = !valid_q[D-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[D-2:0], in_i.valid};
    end
  end

  logic [pyr_pkg::SQW-1:0] sq11_q, sq21_q;
  pyr_pkg::carry_t carry_d, carry_q, carry_s;
  logic [pyr_pkg::ROOTW-1:0] root;

  // The cosine of yaw is zero exactly when both elements are zero.
  always_comb begin
    carry_d.degen   = (in_i.elem_11 == '0) && (in_i.elem_21 == '0);
    carry_d.yaw_y   = in_i.elem_01;
    carry_d.roll_y  = -OPW'(in_i.elem_21);
    carry_d.roll_x  = OPW'(in_i.elem_11);
    if (!carry_d.degen) begin
      carry_d.pitch_y = -OPW'(in_i.elem_02);
      carry_d.pitch_x = OPW'(in_i.elem_00);
    end else if (in_i.elem_01 > 0) begin
      carry_d.pitch_y = OPW'(in_i.elem_20);
      carry_d.pitch_x = OPW'(in_i.elem_22);
    end else begin
      carry_d.pitch_y = OPW'(in_i.elem_20);
      carry_d.pitch_x = OPW'(in_i.elem_10);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq11_q  <= pyr_pkg::SQW'(in_i.elem_11 * in_i.elem_11);
      sq21_q  <= pyr_pkg::SQW'(in_i.elem_21 * in_i.elem_21);
      carry_q <= carry_d;
    end
  end

  pyr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .en_i    (en),
    .sq_a_i  (sq11_q),
    .sq_b_i  (sq21_q),
    .carry_i (carry_q),
    .root_o  (root),
    .carry_o (carry_s)
  );

  pyr_cordic u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (carry_s.pitch_y),
    .x_i     (carry_s.pitch_x),
    .zero_i  (1'b0),
    .angle_o (out_o.pitch_angle)
  );

  pyr_cordic u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (OPW'(carry_s.yaw_y)),
    .x_i     ({1'b0, root}),
    .zero_i  (1'b0),
    .angle_o (out_o.yaw_angle)
  );

  pyr_cordic u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (carry_s.roll_y),
    .x_i     (carry_s.roll_x),
    .zero_i  (carry_s.degen),
    .angle_o (out_o.roll_angle)
  );

  assign out_o.valid = valid_q[D-1];

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready) else $error("input stalled with empty output");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready) else $error("input taken during stall");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> valid_q == $past(valid_q)) else $error("valid bits moved during stall");

endmodule

/* hw/rtl/pyr_sqrt.sv */
module pyr_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pyr_pkg::SQW-1:0]      sq_a_i,
  input  logic [pyr_pkg::SQW-1:0]      sq_b_i,
  input  pyr_pkg::carry_t              carry_i,
  output logic [pyr_pkg::ROOTW-1:0]    root_o,
  output pyr_pkg::carry_t              carry_o
);

  localparam int unsigned N = pyr_pkg::SQRT_STEPS;
  localparam int unsigned W = pyr_pkg::SQW + 1;

  logic [W-1:0]    rem_q  [N];
  logic [W-1:0]    root_q [N];
  pyr_pkg::carry_t car_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
    logic [W-1:0] rem_in, root_in, trial;
    pyr_pkg::carry_t car_in;
    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, sq_a_i} + {1'b0, sq_b_i};
      assign root_in = '0;
      assign car_in  = carry_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign car_in  = car_q[k-1];
    end
    assign trial = root_in + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        car_q[k] <= car_in;
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= (root_in >> 1) + BIT;
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in >> 1;
        end
      end
    end
  end

  assign root_o  = root_q[N-1][pyr_pkg::ROOTW-1:0];
  assign carry_o = car_q[N-1];

endmodule

/* hw/rtl/pyr_cordic.sv */
module pyr_cordic (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [pyr_pkg::OPW-1:0] y_i,
  input  logic signed [pyr_pkg::OPW-1:0] x_i,
  input  logic                           zero_i,
  output logic signed [15:0]             angle_o
);

  localparam int unsigned N  = pyr_pkg::CSTEPS;
  localparam int unsigned CW = pyr_pkg::CW;
  localparam int unsigned ZW = pyr_pkg::ZW;

  logic signed [CW-1:0] x_q [N+1];
  logic signed [CW-1:0] y_q [N+1];
  logic [ZW-1:0]        z_q [N+1];
  logic                 zero_q [N+1];
  logic [15:0]          angle_q;

  logic signed [CW-1:0] x_ext, y_ext;
  assign x_ext = CW'(x_i) <<< pyr_pkg::PRE_SHIFT;
  assign y_ext = CW'(y_i) <<< pyr_pkg::PRE_SHIFT;

  // Fold the left half plane onto the right half with a quarter turn.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= zero_i || (x_i == '0 && y_i == '0);
      if (x_ext < 0) begin
        if (y_ext >= 0) begin
          x_q[0] <= y_ext;
          y_q[0] <= -x_ext;
          z_q[0] <= pyr_pkg::QUARTER_TURN;
        end else begin
          x_q[0] <= -y_ext;
          y_q[0] <= x_ext;
          z_q[0] <= -pyr_pkg::QUARTER_TURN;
        end
      end else begin
        x_q[0] <= x_ext;
        y_q[0] <= y_ext;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic [ZW-1:0] ANG = pyr_pkg::ang_entry(i);
    logic signed [CW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + ANG;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - ANG;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zero_q[N] ? '0 : (z_q[N][ZW-1:16] + {15'b0, z_q[N][15]});
    end
  end

  assign angle_o = angle_q;

endmodule
